/* hw/rtl/frwl_pkg.sv */
// Shared types, constants and codes of the file lock table.
// No dependencies.
package frwl_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int KEY_BITS_DEF   = 32;
    localparam int KIND_COUNT     = 6;
    localparam int CNT_BITS       = 8;

    typedef enum logic [1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_OPTION  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_READ    = 3'd0,
        KIND_LREAD   = 3'd1,
        KIND_APPEND  = 3'd2,
        KIND_LAPPEND = 3'd3,
        KIND_WRITE   = 3'd4,
        KIND_LWRITE  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DENIED  = 3'd2,
        ST_RETRY   = 3'd3,
        ST_BADSLOT = 3'd4,
        ST_ZERO    = 3'd5,
        ST_BADKEY  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_READ,
        S_DECIDE,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/frwl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module frwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/file_reader_writer_lock_table.sv */
// Top level of the file lock table: control sequencer over one slot memory.
// Depends on frwl_pkg and frwl_ram.
//
// Usage: an input transaction (mode, file_key, access_kind, slot_index,
// can_wait, option_value) is taken when in_valid is high and in_stall low.
// Exactly one result transaction (status, granted_slot, access_level,
// delete_option, slot_freed) follows on the out channel, held until the
// receiver drops out_stall. One item is worked on at a time.
// Each slot (key, six 8-bit counters, option) is one word of a memory with
// registered read. Acquire and query scan all SLOT_COUNT slots, one read per
// cycle, then read-modify-write the chosen slot. Release and raise-option
// read the named slot directly. The scan goes through the memory's single
// read port. A finished result sits in the output register, and the next
// item is taken only after the result has been taken. A stalled receiver
// holds the whole block.
// After reset a clearing pass writes every slot to empty, during which
// in_stall stays high.
module file_reader_writer_lock_table
    import frwl_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] file_key,
    input  logic [2:0]  access_kind,
    input  logic [4:0]  slot_index,
    input  logic        can_wait,
    input  logic [1:0]  option_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [4:0]  granted_slot,
    output logic [1:0]  access_level,
    output logic [1:0]  delete_option,
    output logic        slot_freed
);
    localparam int SB = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = SB + 1;
    localparam int WW = KEY_BITS + KIND_COUNT*CNT_BITS + 2;
    localparam int KB = (KEY_BITS < 32) ? KEY_BITS : 32;

    state_t state_reg, state_next;

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [1:0]          mode_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [2:0]          kind_reg;
    logic [4:0]          idx_reg;
    logic                wait_reg;
    logic [1:0]          opt_reg;
    logic                hit_reg, hit_next;
    logic                free_reg, free_next;
    logic [SB-1:0]       hslot_reg, hslot_next;
    logic [SB-1:0]       fslot_reg, fslot_next;
    logic                rvalid_reg;
    logic [SB-1:0]       rslot_reg;

    logic                o_valid_reg;
    logic [2:0]          o_status_reg;
    logic [4:0]          o_slot_reg;
    logic [1:0]          o_level_reg;
    logic [1:0]          o_opt_reg;
    logic                o_freed_reg;

    logic          we;
    logic [SB-1:0] waddr, raddr;
    logic [WW-1:0] wdata, rdata;

    frwl_ram #(.WIDTH(WW), .DEPTH(SLOT_COUNT)) u_slots (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Unpack the slot word
    logic [KEY_BITS-1:0] r_key;
    logic [1:0]          r_opt;
    logic [CNT_BITS-1:0] r_cnt [KIND_COUNT];
    always_comb
    begin
        r_key = rdata[WW-1 -: KEY_BITS];
        r_opt = rdata[1:0];
        for (int i = 0; i < KIND_COUNT; i++)
        begin
            r_cnt[i] = rdata[2 + i*CNT_BITS +: CNT_BITS];
        end
    end

    logic [KEY_BITS-1:0] key_in;
    assign key_in = KEY_BITS'(file_key[KB-1:0]);

    logic       accept;
    logic       idx_ok;
    logic       kind_ok;
    logic       need_scan;
    assign accept    = in_valid && !in_stall;
    assign idx_ok    = ({27'd0, idx_reg} < 32'(SLOT_COUNT));
    assign kind_ok   = (kind_reg < 3'(KIND_COUNT));
    assign need_scan = (mode == MODE_ACQUIRE) || (mode == MODE_QUERY);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_scan ? S_SCAN : S_READ;
                end
            end
            S_CLEAR:
            begin
                if (cnt_reg == CW'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == CW'(SLOT_COUNT))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_DONE;
            S_DONE:
            begin
                if (!o_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Scan tracking: compare each returned slot with the key
    always_comb
    begin
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        free_next  = free_reg;
        hslot_next = hslot_reg;
        fslot_next = fslot_reg;
        if (state_reg == S_IDLE)
        begin
            cnt_next  = '0;
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (state_reg == S_CLEAR || state_reg == S_SCAN)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        if (state_reg == S_SCAN && rvalid_reg)
        begin
            if (r_key == '0)
            begin
                if (!free_reg)
                begin
                    free_next  = 1'b1;
                    fslot_next = rslot_reg;
                end
            end
            else if (r_key == key_reg && !hit_reg)
            begin
                hit_next   = 1'b1;
                hslot_next = rslot_reg;
            end
        end
    end

    // Target slot of the read-modify-write
    logic [SB-1:0] tslot;
    always_comb
    begin
        if (mode_reg == MODE_ACQUIRE || mode_reg == MODE_QUERY)
        begin
            tslot = hit_reg ? hslot_reg : fslot_reg;
        end
        else
        begin
            tslot = SB'(idx_reg);
        end
    end

    // Read address
    always_comb
    begin
        raddr = tslot;
        if (state_reg == S_SCAN)
        begin
            raddr = cnt_reg[SB-1:0];
        end
    end

    // Decide: evaluate the rules on the read slot and build write-back
    logic [2:0]          d_status;
    logic [4:0]          d_slot;
    logic [1:0]          d_level;
    logic [1:0]          d_opt;
    logic                d_freed;
    logic                d_we;
    logic [WW-1:0]       d_wdata;
    logic [CNT_BITS-1:0] n_cnt [KIND_COUNT];
    logic [1:0]          n_opt;
    logic [KEY_BITS-1:0] n_key;
    logic                any_cnt;
    logic                busy;
    logic                ack_ok;
    logic [CNT_BITS-1:0] c_sel;
    always_comb
    begin
        d_status = ST_OK;
        d_slot   = '0;
        d_level  = '0;
        d_opt    = '0;
        d_freed  = 1'b0;
        d_we     = 1'b0;
        n_key    = r_key;
        n_opt    = r_opt;
        any_cnt  = 1'b0;
        ack_ok   = 1'b0;
        for (int i = 0; i < KIND_COUNT; i++)
        begin
            n_cnt[i] = r_cnt[i];
        end
        c_sel = '0;
        for (int i = 0; i < KIND_COUNT; i++)
        begin
            if (kind_reg == 3'(i))
            begin
                c_sel = r_cnt[i];
            end
        end
        busy = (r_cnt[KIND_WRITE] != '0) || (r_cnt[KIND_APPEND] != '0);
        case (mode_t'(mode_reg))
            MODE_ACQUIRE:
            begin
                if (key_reg == '0)
                begin
                    d_status = ST_BADKEY;
                end
                else if (!kind_ok)
                begin
                    d_status = ST_DENIED;
                end
                else if (!hit_reg && !free_reg)
                begin
                    d_status = ST_FULL;
                end
                else if (r_cnt[KIND_LWRITE] != '0)
                begin
                    d_status = ST_DENIED;
                end
                else if (kind_reg >= KIND_APPEND && r_cnt[KIND_LAPPEND] != '0)
                begin
                    d_status = ST_DENIED;
                end
                else if (busy)
                begin
                    d_status = wait_reg ? ST_RETRY : ST_DENIED;
                end
                else if (c_sel == '1)
                begin
                    d_status = ST_DENIED;
                end
                else
                begin
                    ack_ok = 1'b1;
                    d_we   = 1'b1;
                    d_slot = 5'(tslot);
                    n_key  = key_reg;
                    for (int i = 0; i < KIND_COUNT; i++)
                    begin
                        if (kind_reg == 3'(i))
                        begin
                            n_cnt[i] = r_cnt[i] + CNT_BITS'(1);
                        end
                    end
                end
            end
            MODE_RELEASE:
            begin
                if (!idx_ok || r_key == '0)
                begin
                    d_status = ST_BADSLOT;
                end
                else if (!kind_ok)
                begin
                    d_status = ST_DENIED;
                end
                else
                begin
                    d_we  = 1'b1;
                    d_opt = r_opt;
                    if (c_sel == '0)
                    begin
                        d_status = ST_ZERO;
                    end
                    for (int i = 0; i < KIND_COUNT; i++)
                    begin
                        if (kind_reg == 3'(i) && r_cnt[i] != '0)
                        begin
                            n_cnt[i] = r_cnt[i] - CNT_BITS'(1);
                        end
                        any_cnt = any_cnt || (n_cnt[i] != '0);
                    end
                    if (!any_cnt)
                    begin
                        d_freed = 1'b1;
                        n_key   = '0;
                        n_opt   = '0;
                    end
                end
            end
            MODE_QUERY:
            begin
                if (key_reg == '0)
                begin
                    d_status = ST_BADKEY;
                end
                else if (hit_reg)
                begin
                    if (r_cnt[KIND_LWRITE] != '0 || r_cnt[KIND_WRITE] != '0)
                    begin
                        d_level = 2'd3;
                    end
                    else if (r_cnt[KIND_LAPPEND] != '0 || r_cnt[KIND_APPEND] != '0)
                    begin
                        d_level = 2'd2;
                    end
                    else
                    begin
                        d_level = 2'd1;
                    end
                end
            end
            MODE_OPTION:
            begin
                if (!idx_ok || r_key == '0)
                begin
                    d_status = ST_BADSLOT;
                end
                else
                begin
                    d_we = 1'b1;
                    if (opt_reg > r_opt)
                    begin
                        n_opt = opt_reg;
                    end
                    d_opt = n_opt;
                end
            end
            default: d_status = ST_OK;
        endcase
        d_wdata = {n_key, n_cnt[5], n_cnt[4], n_cnt[3], n_cnt[2], n_cnt[1],
                   n_cnt[0], n_opt};
    end

    // Write port: clearing pass or decided write-back
    always_comb
    begin
        we    = 1'b0;
        waddr = tslot;
        wdata = d_wdata;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = cnt_reg[SB-1:0];
            wdata = '0;
        end
        else if (state_reg == S_DECIDE)
        begin
            we = d_we;
        end
    end

    // Handshake outputs
    always_comb
    begin
        in_stall      = (state_reg != S_IDLE);
        out_valid     = o_valid_reg;
        status        = o_status_reg;
        granted_slot  = o_slot_reg;
        access_level  = o_level_reg;
        delete_option = o_opt_reg;
        slot_freed    = o_freed_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            rvalid_reg  <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            hit_reg    <= hit_next;
            free_reg   <= free_next;
            rvalid_reg <= (state_reg == S_SCAN) && (cnt_reg < CW'(SLOT_COUNT));
            if (state_reg == S_DECIDE)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (o_valid_reg && !out_stall)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hslot_reg <= hslot_next;
        fslot_reg <= fslot_next;
        rslot_reg <= cnt_reg[SB-1:0];
        if (accept)
        begin
            mode_reg <= mode;
            key_reg  <= key_in;
            kind_reg <= access_kind;
            idx_reg  <= slot_index;
            wait_reg <= can_wait;
            opt_reg  <= (option_value == 2'd3) ? 2'd2 : option_value;
        end
        if (state_reg == S_DECIDE)
        begin
            o_status_reg <= d_status;
            o_slot_reg   <= d_slot;
            o_level_reg  <= d_level;
            o_opt_reg    <= d_opt;
            o_freed_reg  <= d_freed;
        end
    end

    // A result appears only after a decide step
    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(state_reg == S_DECIDE))
        else $error("result raised outside decide step");

    // No item taken while a result or work is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !o_valid_reg)
        else $error("item accepted with pending result");

    // A granted acquire reports ok
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && ack_ok) |-> (d_status == ST_OK && d_we))
        else $error("grant without ok status");

    // Freeing only on release
    a_free_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && d_freed) |-> (mode_reg == MODE_RELEASE))
        else $error("slot freed outside release");
endmodule
